// ----- src/dbfr_pkg.sv -----
// Shared types, symbol codes and helper functions for the dibit block framer.
// No dependencies; every other file in src uses it by scoped names.

package dbfr_pkg;

   // Default number of bytes in one block.
   localparam int BLOCK_BYTES_DEF = 16;

   // Request kinds carried on req_tuser.
   localparam logic [1:0] REQ_DATA    = 2'd0;
   localparam logic [1:0] REQ_VERDICT = 2'd1;
   localparam logic [1:0] REQ_FLUSH   = 2'd2;

   // Line symbols.
   localparam logic [2:0] SYM_LAST    = 3'd1;
   localparam logic [2:0] SYM_START   = 3'd1;
   localparam logic [2:0] SYM_CS_NEXT = 3'd2;
   localparam logic [2:0] SYM_END     = 3'd3;

   // Group sizes.
   localparam logic [2:0] CNT_CTRL  = 3'd1;
   localparam logic [2:0] CNT_DIBIT = 3'd4;

   localparam int SYM_W   = 3;
   localparam int SUM_W   = 8;
   localparam int REQ_DW  = 16;
   localparam int RSP_DW  = 16;
   localparam int OK_BIT  = 8;

   typedef logic [SYM_W-1:0] sym_type;

   // One result group before it is packed onto rsp_tdata.
   typedef struct packed {
      sym_type    s4;
      sym_type    s3;
      sym_type    s2;
      sym_type    s1;
      logic [2:0] count;
      logic       last;
   } group_type;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] c;
      c = '0;
      for (int i = 0; i < 8; i++) begin
         c = c + {3'b000, v[i]};
      end
      return c;
   endfunction

   // A byte as four clocked dibits, MSB first.
   function automatic group_type dibit_group(input logic [7:0] v);
      group_type g;
      g.s1    = {1'b1, v[7:6]};
      g.s2    = {1'b1, v[5:4]};
      g.s3    = {1'b1, v[3:2]};
      g.s4    = {1'b1, v[1:0]};
      g.count = CNT_DIBIT;
      g.last  = 1'b0;
      return g;
   endfunction

   function automatic group_type ctrl_group(input sym_type s, input logic last);
      group_type g;
      g.s1    = s;
      g.s2    = '0;
      g.s3    = '0;
      g.s4    = '0;
      g.count = CNT_CTRL;
      g.last  = last;
      return g;
   endfunction

endpackage

// ----- src/dibit_block_framer_with_retransmit_core.sv -----
// Top level of the dibit block framer: block buffer memory, frame sequencer
// and output register. Depends on dbfr_pkg.

// Bytes are written into a block memory as they arrive. When a byte fills
// the block, an end-of-input item flushes it, or a failed verdict asks for a
// resend, the framer walks the buffer and emits its groups in order: the
// last-block marker (for the last block only), start, each byte (a memory
// read, then the group with its popcount added to the checksum), then
// checksum-next, checksum and end. The input stays closed while a frame is
// emitted, and for as long as the result side stalls.
// A good verdict for the flush block emits its two end symbols.

module dibit_block_framer_with_retransmit_core #(
   parameter int BLOCK_BYTES = dbfr_pkg::BLOCK_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [dbfr_pkg::REQ_DW-1:0] req_tdata,  // data_byte[7:0], verdict_ok[8], zero
   input  logic                        req_tlast,  // stream_ends
   input  logic [1:0]                  req_tuser,  // req_type
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [dbfr_pkg::RSP_DW-1:0] rsp_tdata,  // sym_first[2:0], sym_second[5:3],
                                                    // sym_third[8:6], sym_fourth[11:9],
                                                    // sym_count[14:12], zero
   output logic                        rsp_tlast   // last
);

   localparam int CNT_W = $clog2(BLOCK_BYTES + 1);
   localparam int IDX_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MARK  = 4'd1;
   localparam logic [3:0] S_START = 4'd2;
   localparam logic [3:0] S_READ  = 4'd3;
   localparam logic [3:0] S_BYTE  = 4'd4;
   localparam logic [3:0] S_CSN   = 4'd5;
   localparam logic [3:0] S_CSUM  = 4'd6;
   localparam logic [3:0] S_END   = 4'd7;
   localparam logic [3:0] S_END2A = 4'd8;
   localparam logic [3:0] S_END2B = 4'd9;

   logic [7:0]                   buf_mem [BLOCK_BYTES];
   logic [7:0]                   rd_data_ff;

   logic [3:0]                   state_ff, state_in;
   logic [CNT_W-1:0]             fill_ff, fill_in;
   logic [CNT_W-1:0]             idx_ff, idx_in;
   logic                         awaiting_ff, awaiting_in;
   logic                         is_last_ff, is_last_in;
   logic                         flush_ff, flush_in;
   logic [dbfr_pkg::SUM_W-1:0]   sum_ff, sum_in;

   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic [dbfr_pkg::RSP_DW-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic                         rsp_tlast_ff, rsp_tlast_in;

   logic                         req_accept;
   logic                         out_free;
   logic                         wr_en;
   logic                         rd_en;
   logic                         emit;
   dbfr_pkg::group_type          grp;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      awaiting_in = awaiting_ff;
      is_last_in  = is_last_ff;
      flush_in    = flush_ff;
      sum_in      = sum_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      emit        = 1'b0;
      grp         = dbfr_pkg::ctrl_group(dbfr_pkg::SYM_END, 1'b0);
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_tuser)
                  dbfr_pkg::REQ_DATA: begin
                     if (!awaiting_ff) begin
                        if (fill_ff < CNT_W'(BLOCK_BYTES)) begin
                           wr_en   = 1'b1;
                           fill_in = fill_ff + CNT_W'(1);
                        end
                        if (fill_in >= CNT_W'(BLOCK_BYTES)) begin
                           is_last_in  = req_tlast;
                           awaiting_in = 1'b1;
                           state_in    = req_tlast ? S_MARK : S_START;
                        end
                     end
                  end
                  dbfr_pkg::REQ_VERDICT: begin
                     if (awaiting_ff) begin
                        if (!req_tdata[dbfr_pkg::OK_BIT]) begin
                           state_in = is_last_ff ? S_MARK : S_START;
                        end else begin
                           if (flush_ff) begin
                              state_in = S_END2A;
                           end
                           awaiting_in = 1'b0;
                           flush_in    = 1'b0;
                           is_last_in  = 1'b0;
                           fill_in     = '0;
                        end
                     end
                  end
                  dbfr_pkg::REQ_FLUSH: begin
                     if (!awaiting_ff) begin
                        is_last_in  = 1'b1;
                        flush_in    = 1'b1;
                        awaiting_in = 1'b1;
                        state_in    = S_MARK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_MARK: begin
            if (out_free) begin
               emit     = 1'b1;
               grp      = dbfr_pkg::ctrl_group(dbfr_pkg::SYM_LAST, 1'b0);
               state_in = S_START;
            end
         end
         S_START: begin
            if (out_free) begin
               emit     = 1'b1;
               grp      = dbfr_pkg::ctrl_group(dbfr_pkg::SYM_START, 1'b0);
               idx_in   = '0;
               sum_in   = '0;
               state_in = (fill_ff == '0) ? S_CSN : S_READ;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_BYTE;
         end
         S_BYTE: begin
            if (out_free) begin
               emit     = 1'b1;
               grp      = dbfr_pkg::dibit_group(rd_data_ff);
               sum_in   = sum_ff + dbfr_pkg::SUM_W'(dbfr_pkg::popcount8(rd_data_ff));
               idx_in   = idx_ff + CNT_W'(1);
               state_in = (idx_in == fill_ff) ? S_CSN : S_READ;
            end
         end
         S_CSN: begin
            if (out_free) begin
               emit     = 1'b1;
               grp      = dbfr_pkg::ctrl_group(dbfr_pkg::SYM_CS_NEXT, 1'b0);
               state_in = S_CSUM;
            end
         end
         S_CSUM: begin
            if (out_free) begin
               emit     = 1'b1;
               grp      = dbfr_pkg::dibit_group(sum_ff);
               state_in = S_END;
            end
         end
         S_END: begin
            if (out_free) begin
               emit     = 1'b1;
               grp      = dbfr_pkg::ctrl_group(dbfr_pkg::SYM_END, 1'b1);
               state_in = S_IDLE;
            end
         end
         S_END2A: begin
            if (out_free) begin
               emit     = 1'b1;
               grp      = dbfr_pkg::ctrl_group(dbfr_pkg::SYM_END, 1'b0);
               state_in = S_END2B;
            end
         end
         S_END2B: begin
            if (out_free) begin
               emit     = 1'b1;
               grp      = dbfr_pkg::ctrl_group(dbfr_pkg::SYM_END, 1'b1);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The output register is refilled in the same cycle its word is taken.
   always_comb begin
      rsp_tvalid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (emit) begin
         rsp_tdata_in = {1'b0, grp.count, grp.s4, grp.s3, grp.s2, grp.s1};
         rsp_tlast_in = grp.last;
      end
   end

   // Bytes are written only while idle and read only while framing, so a
   // write and a read of the same entry never meet.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[fill_ff[IDX_W-1:0]] <= req_tdata[7:0];
      end
      if (rd_en) begin
         rd_data_ff <= buf_mem[idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         idx_ff        <= '0;
         awaiting_ff   <= 1'b0;
         is_last_ff    <= 1'b0;
         flush_ff      <= 1'b0;
         sum_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         idx_ff        <= idx_in;
         awaiting_ff   <= awaiting_in;
         is_last_ff    <= is_last_in;
         flush_ff      <= flush_in;
         sum_ff        <= sum_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

// ----- src/dbfr_checker.sv -----
// Port-level assertions for the dibit block framer, bound to its top level.
// Depends on dbfr_pkg and dibit_block_framer_with_retransmit_core.

module dbfr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [dbfr_pkg::REQ_DW-1:0] req_tdata,
   input logic                        req_tlast,
   input logic [1:0]                  req_tuser,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [dbfr_pkg::RSP_DW-1:0] rsp_tdata,
   input logic                        rsp_tlast
);

   logic [2:0] cnt;
   assign cnt = rsp_tdata[14:12];

   // A stalled word holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cnt == dbfr_pkg::CNT_CTRL) || (cnt == dbfr_pkg::CNT_DIBIT))
      else $error("group size is neither one nor four");

   // Every dibit of a four-symbol group carries the clock bit.
   a_clock: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (cnt == dbfr_pkg::CNT_DIBIT)
         |-> rsp_tdata[2] && rsp_tdata[5] && rsp_tdata[8] && rsp_tdata[11])
      else $error("dibit group without clock bit");

   a_ctrl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (cnt == dbfr_pkg::CNT_CTRL) |-> (rsp_tdata[11:3] == '0))
      else $error("control group with unused symbols set");

   // Each run of results closes on an end symbol.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast
         |-> (cnt == dbfr_pkg::CNT_CTRL) && (rsp_tdata[2:0] == dbfr_pkg::SYM_END))
      else $error("last group is not an end symbol");

endmodule

bind dibit_block_framer_with_retransmit_core dbfr_checker u_dbfr_checker (.*);
